>>> rtl/kmp_pkg.sv
package kmp_pkg;

    localparam int TEXT_W            = 8;
    localparam int LEN_W             = 4;
    localparam int START_W           = 32;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 1;
    localparam int PATTERN_MAX_DEF   = 8;
    localparam int POSITION_BITS_DEF = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

    // control shared by every cell of the chain
    typedef struct packed {
        logic advance;   // a text byte is taken this cycle
        logic flush;     // pattern change, partial matches are dropped
        logic load_pat;  // pattern bytes written this cycle
    } cell_ctrl_t;

endpackage

>>> rtl/kmp_if.sv
interface kmp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       first_of_text;

    modport source (output valid, output text_byte, output first_of_text, input ready);
    modport sink   (input valid, input text_byte, input first_of_text, output ready);
endinterface

interface kmp_result_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [31:0] match_start;

    modport source (output valid, output match_found, output match_start, input ready);
    modport sink   (input valid, input match_found, input match_start, output ready);
endinterface

>>> rtl/kmp_cell.sv
module kmp_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kmp_pkg::cell_ctrl_t       ctrl,
    input  logic [kmp_pkg::TEXT_W-1:0] pat_load,
    input  logic [kmp_pkg::TEXT_W-1:0] text_byte,
    input  logic                      prev_hit,
    output logic                      hit_new,
    output logic                      hit
);
    import kmp_pkg::*;

    logic [TEXT_W-1:0] pat_reg;
    logic [TEXT_W-1:0] pat_next;
    logic              hit_reg;
    logic              hit_next;

    // prefix up to this cell matches the text ending at the current byte
    assign hit_new = prev_hit && (pat_reg == text_byte);

    always_comb
    begin
        pat_next = ctrl.load_pat ? pat_load : pat_reg;
        if (ctrl.flush)
        begin
            hit_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            hit_next = hit_new;
        end
        else
        begin
            hit_next = hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            pat_reg <= pat_next;
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

>>> rtl/kmp_substring_matcher_core.sv
// channel  | dir | transaction payload            | accepted when
// ---------+-----+--------------------------------+--------------------------
// text     | in  | text_byte, first_of_text       | text.valid && text.ready
// result   | out | match_found, match_start       | result.valid && result.ready
// cfg      | in  | cfg_index, cfg_data            | cfg_write
//
// one text byte per cycle unless a held result stalls, one registered result per text
// transaction; the rate is set by the single compare step of the cell chain
// reset clears the cell chain, position counter and result valid, pattern
// bytes to zero and length to one
// a stalled result holds; a new byte is taken in the same cycle the held
// result leaves
module kmp_substring_matcher_core #(
    parameter int PATTERN_MAX   = kmp_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [kmp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kmp_pkg::CFG_DATA_W-1:0]  cfg_data,
    kmp_text_if.sink                       text,
    kmp_result_if.source                   result
);
    import kmp_pkg::*;

    localparam int IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int EXT_W   = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;
    localparam int PAT_W   = PATTERN_MAX * TEXT_W;

    // configuration decode
    logic              wr_pattern;
    logic              wr_length;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  len_eff;
    logic [IDX_W-1:0]  last_idx;

    always_comb
    begin
        wr_pattern = 1'b0;
        wr_length  = 1'b0;
        unique case (cfg_index)
            REG_PATTERN_BYTES:  wr_pattern = cfg_write;
            REG_PATTERN_LENGTH: wr_length  = cfg_write;
            default:            ;
        endcase
    end

    assign len_next = wr_length ? cfg_data[LEN_W-1:0] : len_reg;

    // length zero acts as one, anything above the cell count as the cell count
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(PATTERN_MAX))
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = len_reg;
        end
    end

    assign last_idx = IDX_W'(len_eff - LEN_W'(1));

    // handshake: the result register frees up in the cycle it is drained
    logic accept;
    logic out_valid_reg;
    logic out_valid_next;

    assign text.ready = !out_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;

    // cell chain: cell i says pattern bytes 0..i end at the current byte
    cell_ctrl_t             ctrl;
    logic [PATTERN_MAX-1:0] hit;
    logic [PATTERN_MAX-1:0] hit_new;
    logic [PATTERN_MAX-1:0] prev_hit;
    logic [PATTERN_MAX:0]   chain_in;
    logic [PAT_W-1:0]       pat_load;

    assign ctrl.advance  = accept;
    assign ctrl.flush    = wr_pattern || wr_length;
    assign ctrl.load_pat = wr_pattern;
    assign pat_load      = cfg_data[PAT_W-1:0];

    // cell zero always sees an empty prefix as matched
    assign chain_in = {hit, 1'b1};

    // first_of_text drops partial matches before this byte is compared
    always_comb
    begin
        prev_hit = chain_in[PATTERN_MAX-1:0];
        if (text.first_of_text)
        begin
            prev_hit = PATTERN_MAX'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            kmp_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pat_load  (pat_load[gi*TEXT_W +: TEXT_W]),
                .text_byte (text.text_byte),
                .prev_hit  (prev_hit[gi]),
                .hit_new   (hit_new[gi]),
                .hit       (hit[gi])
            );
        end
    endgenerate

    // position of the current byte, saturating at all ones
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] pos_now;

    assign pos_now = text.first_of_text ? '0 : pos_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = (pos_now == '1) ? pos_now : pos_now + POSITION_BITS'(1);
        end
    end

    // match start is the current position less the pattern length plus one
    logic                     match_now;
    logic [POSITION_BITS-1:0] start_pos;
    logic [EXT_W-1:0]         start_ext;

    assign match_now = hit_new[last_idx];

    always_comb
    begin
        start_pos = '0;
        if (match_now && (pos_now >= POSITION_BITS'(last_idx)))
        begin
            start_pos = pos_now - POSITION_BITS'(last_idx);
        end
    end

    assign start_ext = EXT_W'(start_pos);

    // result register
    logic               found_reg;
    logic               found_next;
    logic [START_W-1:0] start_reg;
    logic [START_W-1:0] start_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            found_next     = match_now;
            start_next     = start_ext[START_W-1:0];
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        start_reg <= start_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.match_found = found_reg;
    assign result.match_start = start_reg;

`ifndef SYNTHESIS
    // a pattern change leaves no partial match behind
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_pattern || wr_length) |=> (hit == '0))
        else $error("cell chain not cleared after pattern change");

    // a restarted text puts the next byte at position one
    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text.first_of_text && !ctrl.flush) |=> (pos_reg == POSITION_BITS'(1)))
        else $error("position not restarted");

    // every text transaction leaves a result waiting
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("text transaction produced no result");
`endif

endmodule

>>> dv/tb_kmp_substring_matcher_core.sv
module tb_kmp_substring_matcher_core;
    import kmp_pkg::*;

    // one expected result per text transaction
    typedef struct {
        bit          found;
        logic [31:0] start;
    } match_rec_t;

    // which registers a configuration step touches
    typedef enum int {
        CFG_BOTH,
        CFG_BYTES_ONLY,
        CFG_LENGTH_ONLY
    } cfg_scope_t;

    // tracks the matcher state and the matches still owed by the block
    class match_tracker;
        logic [63:0]     pattern;
        logic [3:0]      length_reg;
        logic [2:0]      links [8];
        logic [3:0]      matched;
        logic [31:0]     position;
        match_rec_t      owed_matches [$];
        int unsigned     errors;

        function new();
            pattern    = '0;
            length_reg = LEN_RESET;
            position   = '0;
            errors     = 0;
            rebuild_links();
        endfunction

        function int unsigned eff_len();
            int unsigned n;
            n = length_reg;
            if (n == 0) n = 1;
            if (n > 8) n = 8;
            return n;
        endfunction

        function logic [7:0] pat_byte(int unsigned i);
            return 8'(pattern >> (8 * (i % 8)));
        endfunction

        // prefix function over the bytes in use, clears the partial match
        function void rebuild_links();
            int unsigned n;
            int unsigned k;
            n = eff_len();
            k = 0;
            for (int i = 0; i < 8; i++) links[i] = '0;
            for (int unsigned i = 1; i < n; i++)
            begin
                while (k > 0 && pat_byte(k) != pat_byte(i)) k = links[k-1];
                if (pat_byte(k) == pat_byte(i)) k++;
                links[i] = 3'(k);
            end
            matched = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
            if (idx == REG_PATTERN_BYTES)
                pattern = data;
            else if (idx == REG_PATTERN_LENGTH)
                length_reg = data[3:0];
            rebuild_links();
        endfunction

        function void note_text(logic [7:0] b, bit first);
            int unsigned       n;
            int unsigned       k;
            longint unsigned   p;
            match_rec_t        rec;
            n = eff_len();
            if (first)
            begin
                matched  = '0;
                position = '0;
            end
            p = position;
            k = matched;
            if (k >= n) k = 0;
            while (k > 0 && pat_byte(k) != b) k = links[k-1];
            if (pat_byte(k) == b) k++;
            rec.found = 1'b0;
            rec.start = '0;
            if (k == n)
            begin
                rec.found = 1'b1;
                rec.start = (p + 1 >= n) ? 32'(p + 1 - n) : 32'd0;
                k = links[k-1];
            end
            matched = 4'(k);
            if (position != '1) position++;
            owed_matches.insert(owed_matches.size(), rec);
        endfunction

        function void check_result(logic found, logic [31:0] start);
            match_rec_t rec;
            if (owed_matches.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, match_found %0b match_start %0d",
                         $time, found, start);
                return;
            end
            rec = owed_matches.pop_front();
            if (found !== rec.found)
            begin
                errors++;
                $display("%0t: match_found expected %0b actual %0b",
                         $time, rec.found, found);
            end
            if (start !== rec.start)
            begin
                errors++;
                $display("%0t: match_start expected %0d actual %0d",
                         $time, rec.start, start);
            end
        endfunction

        function int unsigned pending();
            return owed_matches.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    kmp_text_if   text_ch ();
    kmp_result_if result_ch ();

    kmp_substring_matcher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text      (text_ch),
        .result    (result_ch)
    );

    match_tracker matcher = new();

    // stimulus helpers: byte alphabet of the current phase and bytes queued for sending
    logic [7:0]   alpha [4];
    int unsigned  alpha_n;
    logic [7:0]   text_plan [$];

    // calm stretches: a side with its flag set never idles
    bit src_calm;
    bit snk_calm;

    // free-running clock, period 4
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // global watchdog, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("tb_kmp_substring_matcher_core NOT OK");
        $finish;
    end

    // result side: random stall before each transaction, then check at the handshake edge
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            matcher.check_result(result_ch.match_found, result_ch.match_start);
        end
    end

    // one text transaction; called at a rising edge, leaves valid high on return
    task automatic send_text(input logic [7:0] b, input bit first);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid         <= 1'b1;
        text_ch.text_byte     <= b;
        text_ch.first_of_text <= first;
        do @(posedge clk); while (text_ch.ready !== 1'b1);
        matcher.note_text(b, first);
    endtask

    // stop sending and let every owed result come back before touching registers
    task automatic drain();
        text_ch.valid <= 1'b0;
        while (matcher.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_one(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        matcher.write_reg(idx, data);
    endtask

    // back-to-back register writes, write enable dropped once at the end
    task automatic configure(input logic [63:0] bytes_val, input logic [63:0] len_val,
                             input cfg_scope_t scope);
        bit len_first;
        len_first = (scope == CFG_BOTH) && ($urandom_range(0, 1) == 1);
        if (len_first) write_one(REG_PATTERN_LENGTH, len_val);
        if (scope != CFG_LENGTH_ONLY) write_one(REG_PATTERN_BYTES, bytes_val);
        if (scope != CFG_BYTES_ONLY && !len_first) write_one(REG_PATTERN_LENGTH, len_val);
        cfg_write <= 1'b0;
    endtask

    // next text byte: mostly pattern copies (some broken) and alphabet filler, a little noise
    function automatic logic [7:0] next_text_byte();
        int unsigned r;
        int unsigned n;
        int unsigned cut;
        int unsigned base;
        if (text_plan.size() == 0)
        begin
            r = $urandom_range(0, 99);
            n = matcher.eff_len();
            if (r < 55)
            begin
                base = text_plan.size();
                for (int unsigned i = 0; i < n; i++)
                    text_plan.insert(text_plan.size(), matcher.pat_byte(i));
                if ($urandom_range(0, 5) == 0)
                begin
                    // broken copy: cut short or one byte corrupted
                    if (n > 1 && $urandom_range(0, 1) == 1)
                    begin
                        cut = $urandom_range(1, n - 1);
                        while (text_plan.size() > base + cut) void'(text_plan.pop_back());
                    end
                    else
                        text_plan[base + $urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
                end
            end
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 3))
                    text_plan.insert(text_plan.size(), alpha[$urandom_range(0, alpha_n - 1)]);
            end
            else
                text_plan.insert(text_plan.size(), 8'($urandom_range(0, 255)));
        end
        return text_plan.pop_front();
    endfunction

    // fresh alphabet and a pattern drawn from it; full-random patterns now and then
    function automatic logic [63:0] new_pattern();
        logic [63:0] p;
        int unsigned mode;
        mode = $urandom_range(0, 3);
        alpha_n = (mode == 0) ? 2 : (mode == 1) ? 3 : (mode == 2) ? 1 : 4;
        for (int j = 0; j < 4; j++)
        begin
            case ($urandom_range(0, 7))
                0:       alpha[j] = 8'h00;
                1:       alpha[j] = 8'hFF;
                default: alpha[j] = 8'($urandom_range(0, 255));
            endcase
        end
        if (mode == 3)
            p = {$urandom, $urandom};
        else
            for (int i = 0; i < 8; i++) p[8*i +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
        return p;
    endfunction

    // length draw: mostly 1 to 8, sometimes zero or above the maximum; upper data bits random
    function automatic logic [63:0] new_length();
        logic [63:0] d;
        int unsigned r;
        d = {$urandom, $urandom};
        r = $urandom_range(0, 11);
        if (r < 8)
            d[3:0] = 4'(r + 1);
        else if (r == 8)
            d[3:0] = 4'd0;
        else
            d[3:0] = 4'($urandom_range(9, 15));
        return d;
    endfunction

    initial
    begin
        int unsigned  random_sent;
        int unsigned  phase_len;
        int unsigned  s;
        cfg_scope_t   scope;

        rst_n                 <= 1'b0;
        cfg_write             <= 1'b0;
        cfg_index             <= REG_PATTERN_BYTES;
        cfg_data              <= '0;
        text_ch.valid         <= 1'b0;
        text_ch.text_byte     <= '0;
        text_ch.first_of_text <= 1'b0;
        result_ch.ready       <= 1'b0;
        src_calm              = 1'b0;
        snk_calm              = 1'b0;
        alpha_n               = 1;
        alpha[0]              = 8'h00;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pattern is a single zero byte
        send_text(8'h00, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);

        // periodic pattern, overlapping matches, then a restart in mid-match
        drain();
        configure(64'h0123_4567_A55A_A55A, 64'd4, CFG_BOTH);
        send_text(8'h5A, 1'b0);
        send_text(8'hA5, 1'b0);
        send_text(8'h5A, 1'b0);
        send_text(8'hA5, 1'b0);
        send_text(8'h5A, 1'b0);
        send_text(8'hA5, 1'b0);
        send_text(8'h5A, 1'b1);
        send_text(8'hA5, 1'b0);

        // length zero behaves as one
        drain();
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, CFG_BOTH);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);

        // length above the maximum behaves as eight, run of zeros overlaps
        drain();
        configure(64'h0, 64'hF, CFG_BOTH);
        send_text(8'h00, 1'b1);
        repeat (8) send_text(8'h00, 1'b0);

        // random phases: new registers, then a stretch of text
        random_sent = 0;
        while (random_sent < 1700)
        begin
            drain();
            s = $urandom_range(0, 5);
            scope = (s == 0) ? CFG_BYTES_ONLY : (s == 1) ? CFG_LENGTH_ONLY : CFG_BOTH;
            configure(new_pattern(), new_length(), scope);
            text_plan.delete();
            phase_len = $urandom_range(15, 80);
            for (int unsigned i = 0; i < phase_len; i++)
            begin
                send_text(next_text_byte(),
                          (i == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 39) == 0));
                random_sent++;
            end
        end

        // wind down: all results back, then a short quiet period
        text_ch.valid <= 1'b0;
        while (matcher.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (matcher.errors == 0 && matcher.pending() == 0)
            $display("tb_kmp_substring_matcher_core OK");
        else
            $display("tb_kmp_substring_matcher_core NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/kmp_pkg.sv
rtl/kmp_if.sv
rtl/kmp_cell.sv
rtl/kmp_substring_matcher_core.sv
dv/tb_kmp_substring_matcher_core.sv
